FILE: src/hop_pkg.sv
// ----------------------------------------------------------------------------
// hop_pkg: shared types and constants of the handshake option parser
// Parse phases, option layouts, result codes and the queue entry and result
// records that pass between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package hop_pkg;

	// Parse phases of the back end
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_DEST,
		PH_TYPE,
		PH_SRC,
		PH_CODE,
		PH_FIXED,
		PH_LEN,
		PH_STR
	} phase_t;

	// Layout of the option body that follows a code byte
	typedef enum logic [2:0] {
		LAY_FIX1,
		LAY_FIX4,
		LAY_FIX8,
		LAY_WIN,
		LAY_LEN1,
		LAY_LEN2,
		LAY_HASH
	} layout_t;

	// Result kinds beyond the option codes
	localparam logic [3:0] KIND_HEADER = 4'd13;
	localparam logic [3:0] KIND_END    = 4'd14;
	localparam logic [3:0] KIND_ERROR  = 4'd15;

	// Handshake classes
	localparam logic [1:0] CLS_INIT   = 2'd0;
	localparam logic [1:0] CLS_FINISH = 2'd1;
	localparam logic [1:0] CLS_ERROR  = 2'd2;
	localparam logic [1:0] CLS_NONE   = 2'd3;

	// Error codes
	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_TYPE    = 3'd1;
	localparam logic [2:0] ERR_VERSION = 3'd2;
	localparam logic [2:0] ERR_ORDER   = 3'd3;
	localparam logic [2:0] ERR_WINDOW  = 3'd4;

	// Option codes with special handling
	localparam logic [3:0] CODE_VERSION = 4'd0;
	localparam logic [3:0] CODE_METHOD  = 4'd6;
	localparam logic [3:0] CODE_CHUNK   = 4'd9;
	localparam logic [3:0] CODE_FSIZE   = 4'd10;
	localparam logic [3:0] CODE_NAME    = 4'd11;
	localparam logic [3:0] CODE_HASH    = 4'd12;

	// Addressing methods
	localparam logic [7:0] METHOD_UNSET = 8'hff;
	localparam logic [7:0] METHOD_0     = 8'd0;
	localparam logic [7:0] METHOD_1     = 8'd1;
	localparam logic [7:0] METHOD_2     = 8'd2;
	localparam logic [7:0] METHOD_3     = 8'd3;
	localparam logic [7:0] METHOD_4     = 8'd4;

	// Byte values and limits
	localparam logic [7:0]  END_BYTE    = 8'hff;
	localparam logic [7:0]  CODE_LIMIT  = 8'd12;
	localparam logic [63:0] VERSION_ONE = 64'd1;
	localparam logic [16:0] COUNT_MAX   = 17'h1ffff;
	localparam logic [15:0] HDR_BYTES   = 16'd4;

	// Queue between front and back end
	localparam int QUEUE_DEPTH = 2;

	// One classified input byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       sof;
		logic       is_end;
		logic       code_bad;
		logic       nonzero;
		layout_t    layout;
	} entry_t;

	// One result record
	typedef struct packed {
		logic [3:0]  item_kind;
		logic [63:0] item_value;
		logic        is_length;
		logic [15:0] byte_index;
		logic [1:0]  handshake_class;
		logic        adopted;
		logic [2:0]  error_code;
		logic [16:0] parsed_length;
		logic        last;
	} result_t;

endpackage

FILE: src/hop_if.sv
// ----------------------------------------------------------------------------
// hop_if: channel interfaces of the handshake option parser
// Byte input stream, result stream and the role register write channel.
// ----------------------------------------------------------------------------
interface hop_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_message;

	modport source (output valid, output data_byte, output start_of_message, input ready);
	modport sink   (input valid, input data_byte, input start_of_message, output ready);
endinterface

interface hop_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  item_kind;
	logic [63:0] item_value;
	logic        is_length;
	logic [15:0] byte_index;
	logic [1:0]  handshake_class;
	logic        adopted;
	logic [2:0]  error_code;
	logic [16:0] parsed_length;
	logic        last;

	modport source (
		output valid, output item_kind, output item_value, output is_length,
		output byte_index, output handshake_class, output adopted,
		output error_code, output parsed_length, output last, input ready
	);
	modport sink (
		input valid, input item_kind, input item_value, input is_length,
		input byte_index, input handshake_class, input adopted,
		input error_code, input parsed_length, input last, output ready
	);
endinterface

interface hop_cfg_if;
	logic valid;
	logic ready;
	logic role_is_leecher;

	modport source (output valid, output role_is_leecher, input ready);
	modport sink   (input valid, input role_is_leecher, output ready);
endinterface

FILE: src/hop_front.sv
// ----------------------------------------------------------------------------
// hop_front: input front end
// Accepts bytes while the queue has room and classifies each one (end byte,
// code range, zero test, option body layout) before it is queued.
// ----------------------------------------------------------------------------
module hop_front import hop_pkg::*; (
	hop_in_if.sink   stream,
	input  logic     q_full,
	output logic     q_push,
	output entry_t   q_entry
);

	layout_t layout;

	// Accept whenever the queue can take the transfer
	assign stream.ready = !q_full;
	assign q_push       = stream.valid && !q_full;

	// Decode the body layout a code byte would select
	always_comb begin
		case (stream.data_byte) inside
			8'd2:        layout = LAY_LEN2;
			8'd8, 8'd11: layout = LAY_LEN1;
			8'd12:       layout = LAY_HASH;
			8'd7:        layout = LAY_WIN;
			8'd9:        layout = LAY_FIX4;
			8'd10:       layout = LAY_FIX8;
			default:     layout = LAY_FIX1;
		endcase
	end

	// Pack the classified byte
	always_comb begin
		q_entry.data_byte = stream.data_byte;
		q_entry.sof       = stream.start_of_message;
		q_entry.is_end    = (stream.data_byte == END_BYTE);
		q_entry.code_bad  = (stream.data_byte > CODE_LIMIT);
		q_entry.nonzero   = (stream.data_byte != 8'd0);
		q_entry.layout    = layout;
	end

endmodule

FILE: src/hop_queue.sv
// ----------------------------------------------------------------------------
// hop_queue: short queue between front and back end
// Holds classified bytes so that input and parse side stall independently.
// ----------------------------------------------------------------------------
module hop_queue import hop_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output entry_t head_entry
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(QUEUE_DEPTH - 1);

	entry_t           slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full       = (count_q == DEPTH_C);
	assign head_valid = (count_q != '0);
	assign head_entry = slot_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	// Store the incoming transfer
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_C) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_C) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: src/hop_back.sv
// ----------------------------------------------------------------------------
// hop_back: parse back end
// Runs the header and option list state machine on one queued byte per cycle
// while the output register is free or draining, and loads each result into it.
// ----------------------------------------------------------------------------
module hop_back import hop_pkg::*; #(
	parameter int HASH_BYTES = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       role_is_leecher,
	input  logic       head_valid,
	input  entry_t     head_entry,
	output logic       pop,
	hop_out_if.source  result
);

	localparam logic [15:0] HASH_LEN = 16'(HASH_BYTES);

	// Parse state
	phase_t      phase_q;
	logic [3:0]  rank_q;
	logic [15:0] fcount_q;
	logic [15:0] flen_q;
	logic [63:0] acc_q;
	logic [7:0]  method_q;
	logic [31:0] dest_q;
	logic [16:0] consumed_q;

	// Output register
	logic        out_valid_q;
	result_t     out_q;

	// Effective state after a possible restart
	phase_t      ph_e;
	logic [3:0]  rank_e;
	logic [15:0] fcount_e;
	logic [15:0] flen_e;
	logic [63:0] acc_e;
	logic [7:0]  method_e;
	logic [31:0] dest_e;
	logic [16:0] consumed_e;

	// Next state
	phase_t      ph_n;
	logic [3:0]  rank_n;
	logic [15:0] fcount_n;
	logic [15:0] flen_n;
	logic [63:0] acc_n;
	logic [7:0]  method_n;
	logic [31:0] dest_n;
	logic [16:0] consumed_n;

	logic        load;
	logic        has_res;
	result_t     res;
	logic [7:0]  b;
	logic [3:0]  code;
	logic [63:0] acc_sh;
	logic [15:0] fc_inc;
	logic [31:0] src;
	logic [15:0] len;

	// Take a byte when the output register is free or draining
	assign load = !out_valid_q || result.ready;
	assign pop  = head_valid && load;

	// Apply a restart before the byte is parsed
	always_comb begin
		if (head_entry.sof) begin
			ph_e       = PH_DEST;
			rank_e     = '0;
			fcount_e   = '0;
			flen_e     = '0;
			acc_e      = '0;
			method_e   = METHOD_UNSET;
			dest_e     = '0;
			consumed_e = '0;
		end else begin
			ph_e       = phase_q;
			rank_e     = rank_q;
			fcount_e   = fcount_q;
			flen_e     = flen_q;
			acc_e      = acc_q;
			method_e   = method_q;
			dest_e     = dest_q;
			consumed_e = consumed_q;
		end
	end

	// Parse one byte
	always_comb begin
		b       = head_entry.data_byte;
		code    = (rank_e != 4'd0) ? rank_e - 4'd1 : 4'd0;
		acc_sh  = {acc_e[55:0], b};
		fc_inc  = fcount_e + 16'd1;
		src     = acc_sh[31:0];
		len     = acc_sh[15:0];

		ph_n       = ph_e;
		rank_n     = rank_e;
		fcount_n   = fcount_e;
		flen_n     = flen_e;
		acc_n      = acc_e;
		method_n   = method_e;
		dest_n     = dest_e;
		consumed_n = consumed_e;
		has_res    = 1'b0;

		if (ph_e != PH_IDLE) begin
			consumed_n = (consumed_e < COUNT_MAX) ? consumed_e + 17'd1 : consumed_e;
		end

		res.item_kind       = 4'd0;
		res.item_value      = '0;
		res.is_length       = 1'b0;
		res.byte_index      = '0;
		res.handshake_class = CLS_NONE;
		res.adopted         = 1'b0;
		res.error_code      = ERR_NONE;
		res.parsed_length   = consumed_n;
		res.last            = 1'b0;

		case (ph_e)
			PH_IDLE: begin
			end
			PH_DEST: begin
				acc_n    = acc_sh;
				fcount_n = fc_inc;
				if (fc_inc >= HDR_BYTES) begin
					dest_n   = acc_sh[31:0];
					acc_n    = '0;
					fcount_n = '0;
					ph_n     = PH_TYPE;
				end
			end
			PH_TYPE: begin
				if (head_entry.nonzero) begin
					ph_n           = PH_IDLE;
					has_res        = 1'b1;
					res.item_kind  = KIND_ERROR;
					res.item_value = 64'(b);
					res.error_code = ERR_TYPE;
					res.last       = 1'b1;
				end else begin
					ph_n = PH_SRC;
				end
			end
			PH_SRC: begin
				acc_n    = acc_sh;
				fcount_n = fc_inc;
				if (fc_inc >= HDR_BYTES) begin
					acc_n          = '0;
					fcount_n       = '0;
					rank_n         = '0;
					ph_n           = PH_CODE;
					has_res        = 1'b1;
					res.item_kind  = KIND_HEADER;
					res.item_value = {dest_e, src};
					if (dest_e == 32'd0 && src != 32'd0) begin
						res.handshake_class = CLS_INIT;
					end else if (dest_e != 32'd0 && src == 32'd0) begin
						res.handshake_class = CLS_FINISH;
					end else begin
						res.handshake_class = CLS_ERROR;
					end
				end
			end
			PH_CODE: begin
				if (head_entry.is_end) begin
					ph_n          = PH_IDLE;
					has_res       = 1'b1;
					res.item_kind = KIND_END;
					res.last      = 1'b1;
				end else if (head_entry.code_bad || b[3:0] < rank_e) begin
					ph_n           = PH_IDLE;
					has_res        = 1'b1;
					res.item_kind  = KIND_ERROR;
					res.item_value = 64'(b);
					res.error_code = ERR_ORDER;
					res.last       = 1'b1;
				end else begin
					rank_n   = b[3:0] + 4'd1;
					fcount_n = '0;
					acc_n    = '0;
					case (head_entry.layout)
						LAY_LEN2: begin
							flen_n = 16'd2;
							ph_n   = PH_LEN;
						end
						LAY_LEN1: begin
							flen_n = 16'd1;
							ph_n   = PH_LEN;
						end
						LAY_HASH: begin
							flen_n = HASH_LEN;
							ph_n   = PH_STR;
						end
						LAY_WIN: begin
							if (method_e == METHOD_0 || method_e == METHOD_2) begin
								flen_n = 16'd4;
								ph_n   = PH_FIXED;
							end else if (method_e == METHOD_1 || method_e == METHOD_3 ||
									method_e == METHOD_4) begin
								flen_n = 16'd8;
								ph_n   = PH_FIXED;
							end else begin
								ph_n           = PH_IDLE;
								has_res        = 1'b1;
								res.item_kind  = KIND_ERROR;
								res.item_value = 64'(b);
								res.error_code = ERR_WINDOW;
								res.last       = 1'b1;
							end
						end
						LAY_FIX4: begin
							flen_n = 16'd4;
							ph_n   = PH_FIXED;
						end
						LAY_FIX8: begin
							flen_n = 16'd8;
							ph_n   = PH_FIXED;
						end
						default: begin
							flen_n = 16'd1;
							ph_n   = PH_FIXED;
						end
					endcase
				end
			end
			PH_FIXED: begin
				acc_n    = acc_sh;
				fcount_n = fc_inc;
				if (fc_inc >= flen_e) begin
					has_res = 1'b1;
					if (code == CODE_VERSION && acc_sh != VERSION_ONE) begin
						ph_n           = PH_IDLE;
						res.item_kind  = KIND_ERROR;
						res.item_value = 64'(b);
						res.error_code = ERR_VERSION;
						res.last       = 1'b1;
					end else begin
						if (code == CODE_METHOD) begin
							method_n = acc_sh[7:0];
						end
						ph_n           = PH_CODE;
						res.item_kind  = code;
						res.item_value = acc_sh;
						res.adopted    = (code == CODE_CHUNK || code == CODE_FSIZE) &&
							role_is_leecher;
					end
				end
			end
			PH_LEN: begin
				acc_n    = acc_sh;
				fcount_n = fc_inc;
				if (fc_inc >= flen_e) begin
					flen_n         = len;
					fcount_n       = '0;
					acc_n          = '0;
					ph_n           = (len != 16'd0) ? PH_STR : PH_CODE;
					has_res        = 1'b1;
					res.item_kind  = code;
					res.item_value = 64'(len);
					res.is_length  = 1'b1;
					res.adopted    = (code == CODE_NAME);
				end
			end
			PH_STR: begin
				fcount_n = fc_inc;
				if (fc_inc >= flen_e) begin
					ph_n = PH_CODE;
				end
				has_res        = 1'b1;
				res.item_kind  = code;
				res.item_value = 64'(b);
				res.byte_index = fcount_e;
				res.adopted    = (code == CODE_NAME) || (code == CODE_HASH && !role_is_leecher);
			end
			default: begin
				ph_n = PH_IDLE;
			end
		endcase
	end

	// Update parse state on each popped byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			rank_q     <= '0;
			fcount_q   <= '0;
			flen_q     <= '0;
			acc_q      <= '0;
			method_q   <= METHOD_UNSET;
			dest_q     <= '0;
			consumed_q <= '0;
		end else if (pop) begin
			phase_q    <= ph_n;
			rank_q     <= rank_n;
			fcount_q   <= fcount_n;
			flen_q     <= flen_n;
			acc_q      <= acc_n;
			method_q   <= method_n;
			dest_q     <= dest_n;
			consumed_q <= consumed_n;
		end
	end

	// Hold or replace the pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= pop && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && has_res) begin
			out_q <= res;
		end
	end

	// Drive the result channel
	assign result.valid           = out_valid_q;
	assign result.item_kind       = out_q.item_kind;
	assign result.item_value      = out_q.item_value;
	assign result.is_length       = out_q.is_length;
	assign result.byte_index      = out_q.byte_index;
	assign result.handshake_class = out_q.handshake_class;
	assign result.adopted         = out_q.adopted;
	assign result.error_code      = out_q.error_code;
	assign result.parsed_length   = out_q.parsed_length;
	assign result.last            = out_q.last;

endmodule

FILE: src/handshake_option_parser_top.sv
// ----------------------------------------------------------------------------
// handshake_option_parser_top: handshake option parser
// Front end classifies bytes, a two-entry queue decouples it from the parse
// back end, whose output register holds the result for the sink.
// ----------------------------------------------------------------------------
// Path: a byte's transfer writes the queue, then the parse step loads its
// result into the output register. Throughput: one byte per cycle unless
// the result side stalls; the parse state machine in the back end updates
// once per byte and the output register drains while the next loads.
// Reset: arst_n clears the queue, the output register, the parse state and
// the role register at once; no clearing pass.
module handshake_option_parser_top import hop_pkg::*; #(
	parameter int HASH_BYTES = 20
) (
	input  logic      clk,
	input  logic      arst_n,
	hop_in_if.sink    stream,
	hop_out_if.source result,
	hop_cfg_if.sink   cfg
);

	logic   role_q;
	logic   q_full;
	logic   q_push;
	entry_t q_entry;
	logic   head_valid;
	entry_t head_entry;
	logic   pop;

	// Role register write
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_q <= 1'b0;
		end else if (cfg.valid) begin
			role_q <= cfg.role_is_leecher;
		end
	end

	hop_front u_front (
		.stream  (stream),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_entry)
	);

	hop_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	hop_back #(
		.HASH_BYTES (HASH_BYTES)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.role_is_leecher (role_q),
		.head_valid      (head_valid),
		.head_entry      (head_entry),
		.pop             (pop),
		.result          (result)
	);

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the handshake option parser
// Streams handshake messages into the byte channel: a directed set of corner
// cases, then random well-formed messages with random content mixed with
// broken ones. A parse predictor in the bench works out the result of each
// accepted byte, and every result transfer is compared against it. Both
// roles are exercised, and the result side holds off for a long stretch once.
// ----------------------------------------------------------------------------
module testbench;
	import hop_pkg::*;

	localparam int HASH_LEN    = 20;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int LONG_HOLD   = 200;
	localparam int SETTLE      = 8;

	// Option codes that the package leaves unnamed
	localparam logic [3:0] CODE_MIN_VERSION = 4'd1;
	localparam logic [3:0] CODE_SWARM_ID    = 4'd2;
	localparam logic [3:0] CODE_INTEGRITY   = 4'd3;
	localparam logic [3:0] CODE_MERKLE      = 4'd4;
	localparam logic [3:0] CODE_SIG_ALG     = 4'd5;
	localparam logic [3:0] CODE_WINDOW      = 4'd7;
	localparam logic [3:0] CODE_SUPPORTED   = 4'd8;

	typedef enum int {
		FAULT_NONE,
		FAULT_TYPE,
		FAULT_VERSION,
		FAULT_ORDER,
		FAULT_HIGH_CODE,
		FAULT_WINDOW,
		FAULT_CUT,
		FAULT_NOISE
	} fault_t;

	typedef struct packed {
		logic [7:0] data;
		logic       sof;
	} msg_byte_t;

	logic clk;
	logic arst_n;

	hop_in_if  in_ch ();
	hop_out_if out_ch ();
	hop_cfg_if cfg_ch ();

	handshake_option_parser_top #(
		.HASH_BYTES(HASH_LEN)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (in_ch),
		.result (out_ch),
		.cfg    (cfg_ch)
	);

	// Bytes waiting to be offered, results waiting to arrive
	msg_byte_t byte_queue[$];
	result_t   results_due[$];

	// Parser state as predicted
	phase_t      prs_phase;
	logic [3:0]  rank_next;
	logic [15:0] fld_cnt;
	logic [15:0] fld_len;
	logic [63:0] acc;
	logic [7:0]  addr_method;
	logic [31:0] dest_chan;
	logic [16:0] bytes_seen;
	logic        leecher;

	// Traffic shaping and bookkeeping
	int unsigned gap_pct;
	int unsigned stall_pct;
	int unsigned send_gap;
	int unsigned hold_cycles;
	bit          long_hold_req;
	int unsigned items_queued;
	int unsigned bytes_accepted;
	int unsigned messages_seen;
	int unsigned results_checked;
	int unsigned mismatches;
	int          cycle_count;
	msg_byte_t   offer;
	result_t     got;
	result_t     want;

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Parse predictor
	// ------------------------------------------------------------------

	function automatic void clear_parse_state();
		prs_phase   = PH_IDLE;
		rank_next   = '0;
		fld_cnt     = '0;
		fld_len     = '0;
		acc         = '0;
		addr_method = METHOD_UNSET;
		dest_chan   = '0;
		bytes_seen  = '0;
	endfunction

	// Build an error result and end the message
	function automatic result_t raise_error(input logic [2:0] err, input logic [7:0] b);
		result_t r;
		r = '0;
		r.item_kind       = KIND_ERROR;
		r.item_value      = {56'd0, b};
		r.handshake_class = CLS_NONE;
		r.error_code      = err;
		r.last            = 1'b1;
		prs_phase = PH_IDLE;
		return r;
	endfunction

	// Advance the parse by one accepted byte and queue any result it causes
	function automatic void parse_byte(input logic [7:0] b, input logic sof);
		result_t     r;
		logic [3:0]  code;
		logic [31:0] src;
		logic        emit;
		r = '0;
		r.handshake_class = CLS_NONE;
		emit = 1'b0;
		if (sof) begin
			clear_parse_state();
			prs_phase = PH_DEST;
		end
		if (prs_phase == PH_IDLE)
			return;
		if (bytes_seen != COUNT_MAX)
			bytes_seen++;
		code = (rank_next != 4'd0) ? rank_next - 4'd1 : 4'd0;

		case (prs_phase)
			PH_DEST: begin
				acc = {acc[55:0], b};
				fld_cnt++;
				if (fld_cnt >= HDR_BYTES) begin
					dest_chan = acc[31:0];
					acc = '0;
					fld_cnt = '0;
					prs_phase = PH_TYPE;
				end
			end
			PH_TYPE: begin
				if (b != 8'h00) begin
					r = raise_error(ERR_TYPE, b);
					emit = 1'b1;
				end else
					prs_phase = PH_SRC;
			end
			PH_SRC: begin
				acc = {acc[55:0], b};
				fld_cnt++;
				if (fld_cnt >= HDR_BYTES) begin
					src = acc[31:0];
					r.item_kind  = KIND_HEADER;
					r.item_value = {dest_chan, src};
					if (dest_chan == 32'd0 && src != 32'd0)
						r.handshake_class = CLS_INIT;
					else if (dest_chan != 32'd0 && src == 32'd0)
						r.handshake_class = CLS_FINISH;
					else
						r.handshake_class = CLS_ERROR;
					acc = '0;
					fld_cnt = '0;
					rank_next = '0;
					prs_phase = PH_CODE;
					emit = 1'b1;
				end
			end
			PH_CODE: begin
				if (b == END_BYTE) begin
					r.item_kind = KIND_END;
					r.last = 1'b1;
					prs_phase = PH_IDLE;
					emit = 1'b1;
				end else if (b > CODE_LIMIT || b < {4'd0, rank_next}) begin
					r = raise_error(ERR_ORDER, b);
					emit = 1'b1;
				end else begin
					rank_next = b[3:0] + 4'd1;
					fld_cnt = '0;
					acc = '0;
					fld_len = 16'd1;
					prs_phase = PH_FIXED;
					case (b[3:0])
						CODE_SWARM_ID: begin
							fld_len = 16'd2;
							prs_phase = PH_LEN;
						end
						CODE_SUPPORTED, CODE_NAME: prs_phase = PH_LEN;
						CODE_HASH: begin
							fld_len = 16'(HASH_LEN);
							prs_phase = PH_STR;
						end
						CODE_WINDOW: begin
							if (addr_method == METHOD_0 || addr_method == METHOD_2)
								fld_len = 16'd4;
							else if (addr_method == METHOD_1 || addr_method == METHOD_3 ||
								addr_method == METHOD_4)
								fld_len = 16'd8;
							else begin
								r = raise_error(ERR_WINDOW, b);
								emit = 1'b1;
							end
						end
						CODE_CHUNK: fld_len = 16'd4;
						CODE_FSIZE: fld_len = 16'd8;
						default: ;
					endcase
				end
			end
			PH_FIXED: begin
				acc = {acc[55:0], b};
				fld_cnt++;
				if (fld_cnt >= fld_len) begin
					if (code == CODE_VERSION && acc != VERSION_ONE)
						r = raise_error(ERR_VERSION, b);
					else begin
						if (code == CODE_METHOD)
							addr_method = acc[7:0];
						r.item_kind  = code;
						r.item_value = acc;
						r.adopted    = (code == CODE_CHUNK || code == CODE_FSIZE) && leecher;
						prs_phase = PH_CODE;
					end
					emit = 1'b1;
				end
			end
			PH_LEN: begin
				acc = {acc[55:0], b};
				fld_cnt++;
				if (fld_cnt >= fld_len) begin
					fld_len = acc[15:0];
					fld_cnt = '0;
					acc = '0;
					if (fld_len != 16'd0)
						prs_phase = PH_STR;
					else
						prs_phase = PH_CODE;
					r.item_kind  = code;
					r.item_value = {48'd0, fld_len};
					r.is_length  = 1'b1;
					r.adopted    = (code == CODE_NAME);
					emit = 1'b1;
				end
			end
			PH_STR: begin
				r.item_kind  = code;
				r.item_value = {56'd0, b};
				r.byte_index = fld_cnt;
				r.adopted    = (code == CODE_NAME) || (code == CODE_HASH && !leecher);
				fld_cnt++;
				if (fld_cnt >= fld_len)
					prs_phase = PH_CODE;
				emit = 1'b1;
			end
			default: prs_phase = PH_IDLE;
		endcase

		if (emit) begin
			r.parsed_length = bytes_seen;
			results_due.push_back(r);
		end
	endfunction

	// ------------------------------------------------------------------
	// Message building
	// ------------------------------------------------------------------

	function automatic void queue_byte(input logic [7:0] b, input logic sof = 1'b0);
		byte_queue.push_back('{data: b, sof: sof});
		items_queued++;
	endfunction

	// Bytes after a message has ended; the parser ignores them
	function automatic void queue_stray(input int unsigned n);
		repeat (n) byte_queue.push_back('{data: 8'($urandom_range(0, 255)), sof: 1'b0});
	endfunction

	// Big-endian field, optionally opening a new message
	function automatic void queue_field(input logic [63:0] value, input int nbytes,
		input logic sof);
		for (int i = nbytes - 1; i >= 0; i--)
			queue_byte(value[8*i +: 8], sof && (i == nbytes - 1));
	endfunction

	function automatic void queue_string(input int unsigned len);
		repeat (len) queue_byte(8'($urandom_range(0, 255)));
	endfunction

	function automatic logic [31:0] pick_channel();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 32'd0;
			4: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 64'd0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// One message: well-formed with random content unless a fault is asked for
	function automatic void queue_message(input fault_t fault);
		logic [7:0]  method;
		logic [7:0]  c;
		int          last_code;
		int unsigned len;
		method = METHOD_UNSET;
		last_code = -1;
		if (fault == FAULT_NOISE) begin
			queue_byte(8'($urandom_range(0, 255)), 1'b1);
			queue_string($urandom_range(1, 30));
			return;
		end
		queue_field({32'd0, pick_channel()}, 4, 1'b1);
		if (fault == FAULT_TYPE) begin
			queue_byte(8'($urandom_range(1, 255)));
			queue_stray($urandom_range(0, 3));
			return;
		end
		queue_byte(8'h00);
		queue_field({32'd0, pick_channel()}, 4, 1'b0);

		for (c = 8'd0; c <= 8'd12; c++) begin
			if (fault == FAULT_CUT && $urandom_range(0, 7) == 0)
				return;
			if (((fault == FAULT_ORDER && last_code >= 0) || fault == FAULT_HIGH_CODE) &&
				$urandom_range(0, 3) == 0)
				break;
			// version nearly always present, other options half the time
			if (c == CODE_VERSION) begin
				if (fault != FAULT_VERSION && $urandom_range(0, 9) == 0)
					continue;
			end else if ($urandom_range(0, 1) == 0)
				continue;
			if (c == CODE_WINDOW && method > METHOD_4 && fault != FAULT_WINDOW)
				continue;
			queue_byte(c);
			last_code = c;
			case (c[3:0])
				CODE_VERSION: begin
					if (fault == FAULT_VERSION) begin
						queue_byte(($urandom_range(0, 1) == 0) ? 8'h00 :
							8'($urandom_range(2, 255)));
						queue_stray($urandom_range(0, 2));
						return;
					end
					queue_byte(VERSION_ONE[7:0]);
				end
				CODE_MIN_VERSION, CODE_INTEGRITY, CODE_MERKLE, CODE_SIG_ALG:
					queue_byte(8'(pick_value()));
				CODE_METHOD: begin
					if (fault == FAULT_WINDOW || $urandom_range(0, 9) == 0)
						method = 8'($urandom_range(5, 255));
					else
						method = 8'($urandom_range(0, 4));
					queue_byte(method);
				end
				CODE_WINDOW: begin
					if (method > METHOD_4) begin
						queue_stray($urandom_range(0, 2));
						return;
					end
					queue_field(pick_value(),
						(method == METHOD_0 || method == METHOD_2) ? 4 : 8, 1'b0);
				end
				CODE_CHUNK: queue_field(pick_value(), 4, 1'b0);
				CODE_FSIZE: queue_field(pick_value(), 8, 1'b0);
				CODE_SWARM_ID: begin
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 300) :
						$urandom_range(0, 6);
					queue_field({48'd0, 16'(len)}, 2, 1'b0);
					queue_string(len);
				end
				CODE_SUPPORTED, CODE_NAME: begin
					len = ($urandom_range(0, 19) == 0) ? 255 : $urandom_range(0, 8);
					queue_byte(8'(len));
					queue_string(len);
				end
				CODE_HASH: queue_string(HASH_LEN);
				default: ;
			endcase
		end

		// close the list, or break it as asked
		if (fault == FAULT_ORDER && last_code >= 0)
			queue_byte(8'($urandom_range(0, last_code)));
		else if (fault == FAULT_ORDER || fault == FAULT_HIGH_CODE)
			queue_byte(8'($urandom_range(13, 254)));
		else
			queue_byte(END_BYTE);
		queue_stray($urandom_range(0, 2));
	endfunction

	function automatic void queue_random_traffic(input int unsigned target);
		int unsigned goal;
		goal = items_queued + target;
		while (items_queued < goal) begin
			if ($urandom_range(0, 99) < 70)
				queue_message(FAULT_NONE);
			else
				queue_message(fault_t'($urandom_range(1, 7)));
		end
	endfunction

	// ------------------------------------------------------------------
	// Sequencing helpers
	// ------------------------------------------------------------------

	// Write the role register; only called while the parser is idle
	task automatic write_role(input logic role);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.role_is_leecher <= role;
		do @(posedge clk); while (!cfg_ch.ready);
		leecher = role;
		cfg_ch.valid <= 1'b0;
	endtask

	// Wait until every byte is sent and every result has arrived
	task automatic wait_idle();
		do @(posedge clk);
		while (byte_queue.size() != 0 || in_ch.valid || results_due.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [63:0] exp_val,
		input logic [63:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h",
				$time, name, exp_val, act_val);
			mismatches++;
		end
	endtask

	// ------------------------------------------------------------------
	// Byte driver
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n) begin
			// predict on every transfer
			if (in_ch.valid && in_ch.ready) begin
				parse_byte(in_ch.data_byte, in_ch.start_of_message);
				bytes_accepted++;
				if (in_ch.start_of_message)
					messages_seen++;
			end
			// offer the next byte once the current one has moved
			if (!in_ch.valid || in_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_ch.valid <= 1'b0;
				end else if (byte_queue.size() != 0 && $urandom_range(0, 99) < gap_pct) begin
					send_gap = $urandom_range(0, 5);
					in_ch.valid <= 1'b0;
				end else if (byte_queue.size() != 0) begin
					offer = byte_queue.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.data_byte <= offer.data;
					in_ch.start_of_message <= offer.sof;
				end else
					in_ch.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n) begin
			// compare each transfer with the oldest prediction
			if (out_ch.valid && out_ch.ready) begin
				got = {out_ch.item_kind, out_ch.item_value, out_ch.is_length,
					out_ch.byte_index, out_ch.handshake_class, out_ch.adopted,
					out_ch.error_code, out_ch.parsed_length, out_ch.last};
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual kind %0d value %0h",
						$time, got.item_kind, got.item_value);
					mismatches++;
				end else begin
					want = results_due.pop_front();
					check_field("item_kind", 64'(want.item_kind), 64'(got.item_kind));
					check_field("item_value", want.item_value, got.item_value);
					check_field("is_length", 64'(want.is_length), 64'(got.is_length));
					check_field("byte_index", 64'(want.byte_index), 64'(got.byte_index));
					check_field("handshake_class", 64'(want.handshake_class),
						64'(got.handshake_class));
					check_field("adopted", 64'(want.adopted), 64'(got.adopted));
					check_field("error_code", 64'(want.error_code), 64'(got.error_code));
					check_field("parsed_length", 64'(want.parsed_length),
						64'(got.parsed_length));
					check_field("last", 64'(want.last), 64'(got.last));
					results_checked++;
				end
			end
			// hold off the result side in bursts, once for a long stretch
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ch.ready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_cycles = LONG_HOLD - 1;
				out_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				hold_cycles = $urandom_range(0, 5);
				out_ch.ready <= 1'b0;
			end else
				out_ch.ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------

	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("%0t: timeout after %0d cycles, %0d results still due",
			$time, CYCLE_LIMIT, results_due.size());
		$display("FAIL handshake_option_parser_top");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus sequence
	// ------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = 8'h00;
		in_ch.start_of_message = 1'b0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.role_is_leecher = 1'b0;
		leecher = 1'b0;
		clear_parse_state();
		gap_pct = 15;
		stall_pct = 15;
		send_gap = 0;
		hold_cycles = 0;
		long_hold_req = 1'b0;
		items_queued = 0;
		bytes_accepted = 0;
		messages_seen = 0;
		results_checked = 0;
		mismatches = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed cases as seeder
		write_role(1'b0);
		// stray byte before any message start
		byte_queue.push_back('{data: 8'hff, sof: 1'b0});
		// bad message type, all-ones destination
		queue_field(64'hffff_ffff, 4, 1'b1);
		queue_byte(8'hff);
		// init class, then a version of zero
		queue_field(64'd0, 4, 1'b1);
		queue_byte(8'h00);
		queue_field(64'hffff_ffff, 4, 1'b0);
		queue_byte(8'(CODE_VERSION));
		queue_byte(8'h00);
		// restart partway into the destination
		queue_byte(8'h12, 1'b1);
		queue_byte(8'h34);
		// finish class, window with no addressing method
		queue_field(64'd1, 4, 1'b1);
		queue_byte(8'h00);
		queue_field(64'd0, 4, 1'b0);
		queue_byte(8'(CODE_WINDOW));
		// error class, empty swarm id, wide window, name, end of list
		queue_field(64'd0, 4, 1'b1);
		queue_byte(8'h00);
		queue_field(64'd0, 4, 1'b0);
		queue_byte(8'(CODE_VERSION));
		queue_byte(VERSION_ONE[7:0]);
		queue_byte(8'(CODE_SWARM_ID));
		queue_field(64'd0, 2, 1'b0);
		queue_byte(8'(CODE_METHOD));
		queue_byte(METHOD_4);
		queue_byte(8'(CODE_WINDOW));
		queue_field('1, 8, 1'b0);
		queue_byte(8'(CODE_NAME));
		queue_byte(8'd1);
		queue_byte(8'h80);
		queue_byte(END_BYTE);
		// code above the last defined one
		queue_field(64'h8000_0001, 4, 1'b1);
		queue_byte(8'h00);
		queue_field(64'h7fff_fffe, 4, 1'b0);
		queue_byte(8'd13);
		wait_idle();

		// Random traffic as leecher, moderate idling
		write_role(1'b1);
		queue_random_traffic(300);
		wait_idle();

		// Seeder, light idling, one long hold on the result side
		write_role(1'b0);
		gap_pct = 5;
		stall_pct = 5;
		queue_random_traffic(300);
		long_hold_req = 1'b1;
		wait_idle();

		// Leecher under heavy idling on both sides
		write_role(1'b1);
		gap_pct = 45;
		stall_pct = 45;
		queue_random_traffic(300);
		wait_idle();

		// Final stretch without idling
		write_role(1'b0);
		gap_pct = 0;
		stall_pct = 0;
		queue_random_traffic(150);
		wait_idle();

		$display("Covered %0d bytes in %0d messages and checked %0d results,",
			bytes_accepted, messages_seen, results_checked);
		$display("in both roles, with random idling and one long result hold-off.");
		if (mismatches == 0)
			$display("PASS handshake_option_parser_top");
		else
			$display("FAIL handshake_option_parser_top");
		$finish;
	end

endmodule
